FILE: design/bl_pkg.sv
`timescale 1ns / 1ps
package bl_pkg;

    localparam int DEF_CAPACITY = 16;
    localparam int KEY_W        = 32;
    localparam int POS_W        = 4;
    localparam int CNT_W        = 5;

    typedef enum logic [1:0] {
        FUNC_CLEAR  = 2'd0,
        FUNC_INSERT = 2'd1,
        FUNC_SEARCH = 2'd2,
        FUNC_REMOVE = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_FULL    = 2'd1,
        ST_EMPTY   = 2'd2,
        ST_MISSING = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_EXEC = 2'd1,
        S_SCAN = 2'd2,
        S_DONE = 2'd3
    } t_state;

    typedef struct packed {
        t_func                    func;
        logic signed [KEY_W-1:0]  key;
    } t_req;

    typedef struct packed {
        t_status           status;
        logic [POS_W-1:0]  position;
        logic [CNT_W-1:0]  count;
    } t_rsp;

    typedef struct packed {
        logic load;
        logic shift;
        logic cmp;
    } t_cell_ctrl;

endpackage

FILE: design/bl_cell.sv
`timescale 1ns / 1ps
module bl_cell
    import bl_pkg::*;
(
    input  logic                    i_clk,
    input  t_cell_ctrl              i_ctrl,
    input  logic signed [KEY_W-1:0] i_key,
    input  logic signed [KEY_W-1:0] i_next,
    output logic signed [KEY_W-1:0] o_entry,
    output logic                    o_hit
);

    logic signed [KEY_W-1:0] r_entry;
    logic                    r_hit;

    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_entry <= i_key;
        end else if (i_ctrl.shift) begin
            r_entry <= i_next;
        end
        if (i_ctrl.cmp) begin
            r_hit <= (r_entry == i_key);
        end
    end

    assign o_entry = r_entry;
    assign o_hit   = r_hit;

endmodule

FILE: design/bl_ctrl.sv
`timescale 1ns / 1ps
module bl_ctrl
    import bl_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_req_valid,
    output logic                    o_req_ready,
    input  t_req                    i_req,
    output logic                    o_rsp_valid,
    input  logic                    i_rsp_ready,
    output t_rsp                    o_rsp,
    input  logic [CAPACITY-1:0]     i_hit,
    output t_cell_ctrl              o_cell [CAPACITY],
    output logic signed [KEY_W-1:0] o_key
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int IW = $clog2(CAPACITY);

    t_state                  r_state, n_state;
    t_func                   r_func;
    logic signed [KEY_W-1:0] r_key;
    logic [CW-1:0]           r_count, n_count;
    logic [CW-1:0]           r_scan, n_scan;
    t_rsp                    r_res, n_res;
    logic                    r_rsp_valid;
    t_rsp                    r_rsp;

    logic accept;
    logic scan_live;
    logic scan_hit;
    logic is_full;

    assign accept    = i_req_valid && o_req_ready;
    assign scan_live = r_scan < r_count;
    assign scan_hit  = scan_live && i_hit[r_scan[IW-1:0]];
    assign is_full   = r_count == CW'(CAPACITY);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == S_DONE && (!r_rsp_valid || i_rsp_ready)) begin
                r_rsp_valid <= 1'b1;
            end else if (i_rsp_ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_req.func;
            r_key  <= i_req.key;
        end
        r_scan <= n_scan;
        r_res  <= n_res;
        if (r_state == S_DONE && (!r_rsp_valid || i_rsp_ready)) begin
            r_rsp <= r_res;
        end
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_scan  = r_scan;
        n_res   = r_res;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_scan  = '0;
                n_state = S_DONE;
                n_res.position = '0;
                n_res.status   = ST_OK;
                case (r_func)
                    FUNC_CLEAR: begin
                        n_count = '0;
                    end
                    FUNC_INSERT: begin
                        if (is_full) begin
                            n_res.status = ST_FULL;
                        end else begin
                            n_count = r_count + 1'b1;
                        end
                    end
                    default: begin
                        if (r_count == '0) begin
                            n_res.status = ST_EMPTY;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                endcase
                n_res.count = CNT_W'(n_count);
            end
            S_SCAN: begin
                if (!scan_live) begin
                    n_res.status   = ST_MISSING;
                    n_res.position = '0;
                    n_state        = S_DONE;
                end else if (scan_hit) begin
                    n_res.status   = ST_OK;
                    n_res.position = POS_W'(r_scan);
                    if (r_func == FUNC_REMOVE) begin
                        n_count = r_count - 1'b1;
                    end
                    n_state = S_DONE;
                end else begin
                    n_scan = r_scan + 1'b1;
                end
                n_res.count = CNT_W'(n_count);
            end
            S_DONE: begin
                if (!r_rsp_valid || i_rsp_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            o_cell[i].cmp   = (r_state == S_EXEC);
            o_cell[i].load  = (r_state == S_EXEC) && (r_func == FUNC_INSERT)
                              && !is_full && (r_count == CW'(i));
            o_cell[i].shift = (r_state == S_SCAN) && (r_func == FUNC_REMOVE)
                              && scan_hit && (CW'(i) >= r_scan);
        end
    end

    assign o_req_ready = (r_state == S_IDLE);
    assign o_rsp_valid = r_rsp_valid;
    assign o_rsp       = r_rsp;
    assign o_key       = r_key;

endmodule

FILE: design/bounded_sequential_list_top.sv
`timescale 1ns / 1ps
// Bounded list of signed 32-bit keys held in insertion order.
// Request channel (i_req_valid / o_req_ready / i_req) carries an operation
// and a key: clear, insert, search or remove. Response channel
// (o_rsp_valid / i_rsp_ready / o_rsp) returns one response per request:
// status, position and the entry count after the operation.
// Each entry sits in a cell; cells compare the key together and, on
// remove, every cell at or past the hit takes its neighbor's entry.
// Steps: a clear or insert, and a search or remove on an empty list, go
// from the execute step straight to the done step, which loads the response
// into the output register once it is free; any other search or remove adds
// one scan step per cell walked, up to and including the hit position, or
// over every entry and a final miss step when the key is absent. A new
// request is taken only once the block is back in idle after loading the
// response, so one request finishes before the next is taken. The scan
// walks the registered compare bits one cell per step.
// Reset empties the list; entries keep no defined value until written.
// A stalled response holds in the output register; the block finishes
// the next request and waits in its final step until the register frees.
module bounded_sequential_list_top
    import bl_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_rsp_valid,
    input  logic i_rsp_ready,
    output t_rsp o_rsp
);

    t_cell_ctrl              cell_ctrl [CAPACITY];
    logic [CAPACITY-1:0]     hit;
    logic signed [KEY_W-1:0] entry [CAPACITY];
    logic signed [KEY_W-1:0] key;

    bl_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .i_req       (i_req),
        .o_rsp_valid (o_rsp_valid),
        .i_rsp_ready (i_rsp_ready),
        .o_rsp       (o_rsp),
        .i_hit       (hit),
        .o_cell      (cell_ctrl),
        .o_key       (key)
    );

    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        bl_cell u_cell (
            .i_clk   (i_clk),
            .i_ctrl  (cell_ctrl[g]),
            .i_key   (key),
            .i_next  ((g == CAPACITY - 1) ? entry[g] : entry[(g + 1) % CAPACITY]),
            .o_entry (entry[g]),
            .o_hit   (hit[g])
        );
    end

    a_fail_pos_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.status != ST_OK) |-> o_rsp.position == '0)
        else $error("failed request reports a nonzero position");

    a_empty_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp_valid && (o_rsp.status == ST_EMPTY) |-> o_rsp.count == '0)
        else $error("empty status with nonzero count");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && o_req_ready |=> !o_req_ready)
        else $error("request taken while previous one still in work");

endmodule
